@@ sv/lgm_pkg.sv @@
`timescale 1ns / 1ps
package lgm_pkg;

	localparam int MAX_DIM       = 4096;
	localparam int FRAC_BITS_DEF = 16;

	localparam int DIM_W   = 13;
	localparam int POS_W   = 12;
	localparam int INV_W   = 18;
	localparam int FIX_W   = 24;
	localparam int LEVEL_W = 16;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;
	localparam int IDX_W   = 3;
	localparam int NSTAGE  = 4;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_INV_HALF_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_INV_HALF_HEIGHT = 3'd3;
	localparam logic [IDX_W-1:0] REG_CENTER_X        = 3'd4;
	localparam logic [IDX_W-1:0] REG_CENTER_Y        = 3'd5;
	localparam logic [IDX_W-1:0] REG_GRAD_X          = 3'd6;
	localparam logic [IDX_W-1:0] REG_GRAD_Y          = 3'd7;

	typedef struct packed {
		logic [DIM_W-1:0]        image_width;
		logic [DIM_W-1:0]        image_height;
		logic [INV_W-1:0]        inv_half_width;
		logic [INV_W-1:0]        inv_half_height;
		logic signed [FIX_W-1:0] center_x;
		logic signed [FIX_W-1:0] center_y;
		logic signed [FIX_W-1:0] grad_x;
		logic signed [FIX_W-1:0] grad_y;
	} lgm_cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             eor;
		logic             eof;
	} lgm_pos_t;

	// load[k]: stage k+1 of the datapath takes a new pixel this cycle
	typedef struct packed {
		logic [NSTAGE-1:0] load;
		lgm_pos_t          pos;
	} lgm_cmd_t;

	// zero acts as one, anything past MAX_DIM acts as MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

endpackage

@@ sv/lgm_ifs.sv @@
`timescale 1ns / 1ps
interface lgm_req_if import lgm_pkg::*; ();
	logic valid;
	logic ready;
	logic restart;
	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface lgm_pix_if import lgm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic [POS_W-1:0]   pixel_col;
	logic [POS_W-1:0]   pixel_row;
	logic               end_of_row;
	logic               end_of_frame;
	modport source (output valid, output level, output pixel_col, output pixel_row,
		output end_of_row, output end_of_frame, input ready);
	modport sink (input valid, input level, input pixel_col, input pixel_row,
		input end_of_row, input end_of_frame, output ready);
endinterface

@@ sv/lgm_regs.sv @@
`timescale 1ns / 1ps
module lgm_regs import lgm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output lgm_cfg_t          cfg
);

	lgm_cfg_t         cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= DIM_W'(1);
			cfg_q.image_height    <= DIM_W'(1);
			cfg_q.inv_half_width  <= INV_W'(131072);
			cfg_q.inv_half_height <= INV_W'(131072);
			cfg_q.center_x        <= '0;
			cfg_q.center_y        <= '0;
			cfg_q.grad_x          <= '0;
			cfg_q.grad_y          <= FIX_W'(65536);
		end else if (wr_en) begin
			case (idx)
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= pwdata[DIM_W-1:0];
				REG_INV_HALF_WIDTH:  cfg_q.inv_half_width  <= pwdata[INV_W-1:0];
				REG_INV_HALF_HEIGHT: cfg_q.inv_half_height <= pwdata[INV_W-1:0];
				REG_CENTER_X:        cfg_q.center_x        <= pwdata[FIX_W-1:0];
				REG_CENTER_Y:        cfg_q.center_y        <= pwdata[FIX_W-1:0];
				REG_GRAD_X:          cfg_q.grad_x          <= pwdata[FIX_W-1:0];
				REG_GRAD_Y:          cfg_q.grad_y          <= pwdata[FIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IMAGE_WIDTH:     prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_q.image_width};
			REG_IMAGE_HEIGHT:    prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_q.image_height};
			REG_INV_HALF_WIDTH:  prdata = {{(DATA_W-INV_W){1'b0}}, cfg_q.inv_half_width};
			REG_INV_HALF_HEIGHT: prdata = {{(DATA_W-INV_W){1'b0}}, cfg_q.inv_half_height};
			REG_CENTER_X:        prdata = {{(DATA_W-FIX_W){1'b0}}, cfg_q.center_x};
			REG_CENTER_Y:        prdata = {{(DATA_W-FIX_W){1'b0}}, cfg_q.center_y};
			REG_GRAD_X:          prdata = {{(DATA_W-FIX_W){1'b0}}, cfg_q.grad_x};
			REG_GRAD_Y:          prdata = {{(DATA_W-FIX_W){1'b0}}, cfg_q.grad_y};
			default:             prdata = '0;
		endcase
	end

endmodule

@@ sv/lgm_ctrl.sv @@
`timescale 1ns / 1ps
module lgm_ctrl import lgm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  lgm_cfg_t cfg,
	input  logic     in_valid,
	input  logic     restart,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output lgm_cmd_t cmd
);

	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] space;
	logic [NSTAGE-1:0] load;
	logic [POS_W-1:0]  col_q;
	logic [POS_W-1:0]  row_q;

	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [POS_W-1:0]  col0;
	logic [POS_W-1:0]  row0;
	logic [POS_W-1:0]  col;
	logic [POS_W-1:0]  row;
	logic              eor;
	logic              eof;

	// a stage has room when empty or when its pixel moves on this cycle
	always_comb begin
		space[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready;
		for (int k = NSTAGE - 2; k >= 0; k--)
			space[k] = !vld_q[k] || space[k+1];
		load[0] = in_valid && space[0];
		for (int k = 1; k < NSTAGE; k++)
			load[k] = vld_q[k-1] && space[k];
	end

	assign in_ready  = space[0];
	assign out_valid = vld_q[NSTAGE-1];

	// scan position of the pixel being requested
	always_comb begin
		w_eff = eff_dim(cfg.image_width);
		h_eff = eff_dim(cfg.image_height);
		col0  = restart ? '0 : col_q;
		row0  = restart ? '0 : row_q;
		col   = ({1'b0, col0} >= w_eff) ? '0 : col0;
		row   = ({1'b0, row0} >= h_eff) ? '0 : row0;
		eor   = ({1'b0, col} == w_eff - DIM_W'(1));
		eof   = eor && ({1'b0, row} == h_eff - DIM_W'(1));
	end

	assign cmd.load    = load;
	assign cmd.pos.col = col;
	assign cmd.pos.row = row;
	assign cmd.pos.eor = eor;
	assign cmd.pos.eof = eof;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			vld_q <= load | (vld_q & ~space);
			if (load[0]) begin
				if (eor) begin
					col_q <= '0;
					row_q <= eof ? '0 : row + POS_W'(1);
				end else begin
					col_q <= col + POS_W'(1);
					row_q <= row;
				end
			end
		end
	end

endmodule

@@ sv/lgm_dp.sv @@
`timescale 1ns / 1ps
module lgm_dp import lgm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  lgm_cfg_t           cfg,
	input  lgm_cmd_t           cmd,
	output logic [LEVEL_W-1:0] level,
	output lgm_pos_t           pos
);

	localparam int PROD_W  = POS_W + INV_W;
	localparam int COORD_W = PROD_W + 2;
	localparam int MUL_W   = COORD_W + FIX_W;
	localparam int SUM_W   = MUL_W + 1;
	localparam int SHL     = (FRAC_BITS < LEVEL_W) ? LEVEL_W - FRAC_BITS : 0;
	localparam int SHR     = (FRAC_BITS > LEVEL_W) ? FRAC_BITS - LEVEL_W : 0;
	localparam int SC_W    = FRAC_BITS + 1 + SHL;

	localparam logic signed [COORD_W-1:0] ONE_C = COORD_W'(64'd1 << FRAC_BITS);
	localparam logic signed [SUM_W-1:0]   ONE_S = SUM_W'(64'd1 << FRAC_BITS);

	logic [PROD_W-1:0]         xprod_s1, yprod_s1;
	lgm_pos_t                  pos_s1;
	logic signed [COORD_W-1:0] xx_s2, yy_s2;
	lgm_pos_t                  pos_s2;
	logic signed [MUL_W-1:0]   px_s3, py_s3;
	lgm_pos_t                  pos_s3;
	logic [LEVEL_W-1:0]        level_s4;
	lgm_pos_t                  pos_s4;

	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   proj;
	logic signed [SUM_W-1:0]   lev;
	logic signed [SUM_W-1:0]   lev_c;
	logic [SC_W-1:0]           scaled;
	logic [LEVEL_W-1:0]        level_d;

	always_ff @(posedge clk) begin
		if (cmd.load[0]) begin
			xprod_s1 <= PROD_W'(cmd.pos.col) * PROD_W'(cfg.inv_half_width);
			yprod_s1 <= PROD_W'(cmd.pos.row) * PROD_W'(cfg.inv_half_height);
			pos_s1   <= cmd.pos;
		end
		if (cmd.load[1]) begin
			xx_s2  <= signed'({2'b00, xprod_s1}) - ONE_C - COORD_W'(cfg.center_x);
			yy_s2  <= signed'({2'b00, yprod_s1}) - ONE_C - COORD_W'(cfg.center_y);
			pos_s2 <= pos_s1;
		end
		if (cmd.load[2]) begin
			px_s3  <= MUL_W'(xx_s2) * MUL_W'(cfg.grad_x);
			py_s3  <= MUL_W'(yy_s2) * MUL_W'(cfg.grad_y);
			pos_s3 <= pos_s2;
		end
		if (cmd.load[3]) begin
			level_s4 <= level_d;
			pos_s4   <= pos_s3;
		end
	end

	// floor of the projection, then clamp 1 - p to [0, 1] and rescale to Q0.16
	always_comb begin
		sum  = SUM_W'(px_s3) + SUM_W'(py_s3);
		proj = sum >>> FRAC_BITS;
		lev  = ONE_S - proj;
		if (lev < 0)
			lev_c = '0;
		else if (lev > ONE_S)
			lev_c = ONE_S;
		else
			lev_c = lev;
		scaled = (SC_W'(lev_c[FRAC_BITS:0]) << SHL) >> SHR;
		if (scaled > SC_W'({LEVEL_W{1'b1}}))
			level_d = '1;
		else
			level_d = scaled[LEVEL_W-1:0];
	end

	assign level = level_s4;
	assign pos   = pos_s4;

endmodule

@@ sv/linear_gradient_mask_generator.sv @@
`timescale 1ns / 1ps
// Linear gradient mask generator: one pixel per request, raster order.
// An accepted request passes the stage registers s1 to s4 before its pixel reaches the output.
// Throughput: one pixel per cycle while pix.ready is high, set by a four-stage datapath
// (multiply by reciprocal, center offset, gradient multiply, sum and clamp).
// Reset (arst_n low): pipeline emptied, scan at pixel (0,0), registers to defaults.
module linear_gradient_mask_generator import lgm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	lgm_req_if.sink           req,
	lgm_pix_if.source         pix
);

	lgm_cfg_t cfg;
	lgm_cmd_t cmd;
	lgm_pos_t pos;

	lgm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lgm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (req.valid),
		.restart   (req.restart),
		.in_ready  (req.ready),
		.out_valid (pix.valid),
		.out_ready (pix.ready),
		.cmd       (cmd)
	);

	lgm_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk   (clk),
		.cfg   (cfg),
		.cmd   (cmd),
		.level (pix.level),
		.pos   (pos)
	);

	assign pix.pixel_col    = pos.col;
	assign pix.pixel_row    = pos.row;
	assign pix.end_of_row   = pos.eor;
	assign pix.end_of_frame = pos.eof;

	a_restart_origin: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.restart |-> cmd.pos.col == '0 && cmd.pos.row == '0)
		else $error("restart request did not start at the first pixel");

	a_eof_is_eor: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.end_of_frame |-> pix.end_of_row)
		else $error("end of frame without end of row");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> {1'b0, pix.pixel_col} < eff_dim(cfg.image_width))
		else $error("pixel column outside the image width");

	a_eor_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && cmd.pos.eor |=> u_ctrl.col_q == '0)
		else $error("column counter did not wrap after end of row");

endmodule
